// File: sv/llwm_pkg.sv
// package for the liquid level window monitor
// shared constants, register indexes and controller/datapath command types
`timescale 1ns / 1ps

package llwm_pkg;

	localparam int SENSORS_DEF       = 4;
	localparam int WINDOW_MAX_DEF    = 16;
	localparam int LOW_DEBOUNCE_DEF  = 3;
	localparam int HIGH_DEBOUNCE_DEF = 3;

	localparam logic [2:0] REG_WINDOW_SIZE = 3'd0;
	localparam logic [2:0] REG_CONV_GAIN   = 3'd1;
	localparam logic [2:0] REG_CONV_OFFSET = 3'd2;
	localparam logic [2:0] REG_VALID_MIN   = 3'd3;
	localparam logic [2:0] REG_VALID_MAX   = 3'd4;
	localparam logic [2:0] REG_TANK_HEIGHT = 3'd5;
	localparam logic [2:0] REG_LOW_THRESH  = 3'd6;
	localparam logic [2:0] REG_HIGH_THRESH = 3'd7;

	localparam logic [2:0] ZONE_LOW  = 3'b001;
	localparam logic [2:0] ZONE_IN   = 3'b010;
	localparam logic [2:0] ZONE_HIGH = 3'b100;
	localparam logic [2:0] LED_RED   = 3'b001;
	localparam logic [2:0] LED_BLUE  = 3'b010;
	localparam logic [2:0] LED_GREEN = 3'b100;

	localparam logic [1:0] TEV_NONE = 2'd0;
	localparam logic [1:0] TEV_LOW  = 2'd1;
	localparam logic [1:0] TEV_HIGH = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture input word
		logic conv;      // register product
		logic check;     // register reading and validity
		logic rd_old;    // memory read of the oldest entry
		logic update;    // write window, update sum and state
		logic div_start; // start mean divider
		logic div_step;  // one divider step
		logic classify;  // threshold classification
		logic finish;    // build result word
	} llwm_cmd_t;

	// status back to controller
	typedef struct packed {
		logic skip;      // sensor index out of range
		logic ok;        // valid sample
		logic report;    // report due after update
		logic div_done;
	} llwm_sts_t;

endpackage

// File: sv/liquid_level_window_monitor_unit.sv
// liquid level window monitor, one word at a time; window entries tracked by valid bits
// steps: load, convert, check, then finish for a fault or skipped word; a valid word
// reads the oldest entry and updates, and for a report runs the serial mean divider
// (one quotient bit a cycle) and classifies; a new word waits until output is taken;
// asynchronous active-low reset clears sensor state, configuration and control flags
`timescale 1ns / 1ps

module liquid_level_window_monitor_unit #(
	parameter int SENSORS       = llwm_pkg::SENSORS_DEF,
	parameter int WINDOW_MAX    = llwm_pkg::WINDOW_MAX_DEF,
	parameter int LOW_DEBOUNCE  = llwm_pkg::LOW_DEBOUNCE_DEF,
	parameter int HIGH_DEBOUNCE = llwm_pkg::HIGH_DEBOUNCE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  sensor_index,
	input  logic        sensor_connected,
	input  logic [11:0] adc_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  sensor_id,
	output logic        report_valid,
	output logic [14:0] level_mm,
	output logic        sensor_fault_event,
	output logic [1:0]  threshold_event,
	output logic [2:0]  led_state,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	llwm_pkg::llwm_cmd_t cmd;
	llwm_pkg::llwm_sts_t sts;

	assign cfg_ready = 1'b1;

	llwm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
	);

	llwm_dp #(
		.SENSORS(SENSORS), .WINDOW_MAX(WINDOW_MAX),
		.LOW_DEBOUNCE(LOW_DEBOUNCE), .HIGH_DEBOUNCE(HIGH_DEBOUNCE)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.sensor_index, .sensor_connected, .adc_code,
		.sensor_id, .report_valid, .level_mm, .sensor_fault_event,
		.threshold_event, .led_state
	);

endmodule

// File: sv/llwm_ctrl.sv
// controller state machine for the liquid level window monitor
// depends on llwm_pkg
`timescale 1ns / 1ps

module llwm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output llwm_pkg::llwm_cmd_t  cmd,
	input  llwm_pkg::llwm_sts_t  sts
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CONV, ST_CHECK, ST_RDOLD, ST_UPDATE, ST_DIVST, ST_DIV,
		ST_CLASS, ST_FINISH, ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.conv      = (state_q == ST_CONV);
		cmd.check     = (state_q == ST_CHECK);
		cmd.rd_old    = (state_q == ST_RDOLD);
		cmd.update    = (state_q == ST_UPDATE);
		cmd.div_start = (state_q == ST_DIVST);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.classify  = (state_q == ST_CLASS);
		cmd.finish    = (state_q == ST_FINISH);
	end

	// sequencer, output word held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_CONV;
				ST_CONV:   state_q <= ST_CHECK;
				ST_CHECK:  state_q <= (sts.skip || !sts.ok) ? ST_FINISH : ST_RDOLD;
				ST_RDOLD:  state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= sts.report ? ST_DIVST : ST_FINISH;
				ST_DIVST:  state_q <= ST_DIV;
				ST_DIV:    if (sts.div_done) state_q <= ST_CLASS;
				ST_CLASS:  state_q <= ST_FINISH;
				ST_FINISH: begin
					state_q     <= ST_OUT;
					out_valid_q <= 1'b1;
				end
				ST_OUT: if (!out_stall) begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result shown only in the output state
	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT) else $error("out_valid outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_CONV) else $error("load did not start conversion");
	a_div_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == ST_DIV) else $error("divider start lost");

endmodule

// File: sv/llwm_dp.sv
// datapath: conversion, per-sensor window memory and state, serial divider
// depends on llwm_pkg
`timescale 1ns / 1ps

module llwm_dp #(
	parameter int SENSORS       = llwm_pkg::SENSORS_DEF,
	parameter int WINDOW_MAX    = llwm_pkg::WINDOW_MAX_DEF,
	parameter int LOW_DEBOUNCE  = llwm_pkg::LOW_DEBOUNCE_DEF,
	parameter int HIGH_DEBOUNCE = llwm_pkg::HIGH_DEBOUNCE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  llwm_pkg::llwm_cmd_t cmd,
	output llwm_pkg::llwm_sts_t sts,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          sensor_index,
	input  logic                sensor_connected,
	input  logic [11:0]         adc_code,
	output logic [1:0]          sensor_id,
	output logic                report_valid,
	output logic [14:0]         level_mm,
	output logic                sensor_fault_event,
	output logic [1:0]          threshold_event,
	output logic [2:0]          led_state
);

	localparam int SW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int PW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int MD  = SENSORS * WINDOW_MAX;
	localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
	localparam int SUMW = 15 + $clog2(WINDOW_MAX + 1);
	localparam logic [4:0] WMAX5 = 5'(WINDOW_MAX);

	// configuration registers
	logic [4:0]         window_size_q;
	logic [15:0]        conv_gain_q;
	logic signed [15:0] conv_offset_q;
	logic [14:0]        valid_min_q, valid_max_q, tank_height_q, low_thr_q, high_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= 5'd1;
			conv_gain_q   <= 16'd256;
			conv_offset_q <= '0;
			valid_min_q   <= '0;
			valid_max_q   <= 15'h7fff;
			tank_height_q <= 15'd2000;
			low_thr_q     <= '0;
			high_thr_q    <= 15'h7fff;
		end else if (cfg_valid) begin
			case (cfg_index)
				llwm_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data[4:0];
				llwm_pkg::REG_CONV_GAIN:   conv_gain_q   <= cfg_data;
				llwm_pkg::REG_CONV_OFFSET: conv_offset_q <= cfg_data;
				llwm_pkg::REG_VALID_MIN:   valid_min_q   <= cfg_data[14:0];
				llwm_pkg::REG_VALID_MAX:   valid_max_q   <= cfg_data[14:0];
				llwm_pkg::REG_TANK_HEIGHT: tank_height_q <= cfg_data[14:0];
				llwm_pkg::REG_LOW_THRESH:  low_thr_q     <= cfg_data[14:0];
				llwm_pkg::REG_HIGH_THRESH: high_thr_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// effective window size
	logic [4:0] size;
	always_comb begin
		if (window_size_q == 5'd0) size = 5'd1;
		else if ({27'd0, window_size_q} > 32'(WINDOW_MAX)) size = WMAX5;
		else size = window_size_q;
	end

	// captured input word
	logic [1:0]  sidx_q;
	logic        conn_q;
	logic [11:0] code_q;
	logic        skip_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skip_q <= 1'b0;
		else if (cmd.load) skip_q <= ({30'd0, sensor_index} >= 32'(SENSORS));
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sidx_q <= sensor_index;
			conn_q <= sensor_connected;
			code_q <= adc_code;
		end
	end
	wire [SW-1:0] s = SW'(sidx_q);

	// product register
	logic [27:0] prod_q;
	always_ff @(posedge clk) if (cmd.conv) prod_q <= code_q * conv_gain_q;

	// reading, saturation and validity
	logic signed [21:0] r_raw;
	logic signed [16:0] r_sat;
	logic [15:0]        mag;
	logic signed [17:0] lv;
	always_comb begin
		r_raw = $signed({2'b0, prod_q[27:8]}) + 22'(conv_offset_q);
		if (r_raw > 22'sd32767) r_sat = 17'sd32767;
		else if (r_raw < -22'sd32767) r_sat = -17'sd32767;
		else r_sat = 17'(r_raw);
		mag = r_sat[16] ? 16'(-r_sat) : 16'(r_sat);
		lv  = $signed({3'b0, tank_height_q}) - 18'(r_sat);
	end

	// validity of the word under check
	logic ok_now;
	assign ok_now = conn_q && !skip_q && mag >= {1'b0, valid_min_q}
		&& mag <= {1'b0, valid_max_q} && !lv[17]
		&& lv <= $signed({3'b0, tank_height_q});

	logic        ok_q;
	logic [14:0] level_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok_q <= 1'b0;
		else if (cmd.check) ok_q <= ok_now;
	end
	always_ff @(posedge clk) if (cmd.check) level_q <= lv[14:0];

	// per-sensor state
	logic [SUMW-1:0] sum_q   [SENSORS];
	logic [PW:0]     wpos_q  [SENSORS];
	logic            full_q  [SENSORS];
	logic [4:0]      ssr_q   [SENSORS];
	logic            erep_q  [SENSORS];
	logic [2:0]      zone_q  [SENSORS];
	logic [3:0]      lowc_q  [SENSORS];
	logic [3:0]      inc_q   [SENSORS];
	logic [3:0]      highc_q [SENSORS];
	logic [2:0]      led_q   [SENSORS];
	logic [MD-1:0]   wvalid_q;

	// window memory, invalid entries read as zero
	logic [14:0] mem [MD];
	logic [14:0] old_rd_s1;
	logic        old_vld_s1;
	logic [PW-1:0] p;
	logic [AW-1:0] addr;
	always_comb begin
		p = (wpos_q[s] >= (PW+1)'(WINDOW_MAX)) ? '0 : wpos_q[s][PW-1:0];
		addr = AW'(s) * AW'(WINDOW_MAX) + AW'(p);
	end
	always_ff @(posedge clk) begin
		if (cmd.rd_old) begin
			old_rd_s1  <= mem[addr];
			old_vld_s1 <= wvalid_q[addr];
		end
		if (cmd.update) mem[addr] <= level_q;
	end
	wire [14:0] old_val = old_vld_s1 ? old_rd_s1 : 15'd0;

	// next-state values of an update
	logic [SUMW-1:0] new_sum;
	logic [4:0]      new_ssr;
	logic [PW:0]     pn;
	logic            new_full, rep;
	always_comb begin
		new_sum  = sum_q[s] - SUMW'(old_val) + SUMW'(level_q);
		new_ssr  = (ssr_q[s] < 5'd31) ? ssr_q[s] + 5'd1 : ssr_q[s];
		pn       = (PW+1)'(p) + 1'b1;
		new_full = full_q[s];
		if (32'(pn) >= 32'(size)) begin
			new_full = 1'b1;
			pn = '0;
		end
		rep = new_full && new_ssr >= size;
	end

	// serial restoring divider: sum / size
	logic [SUMW-1:0] quo_q;
	logic [5:0]      rem_q;
	logic [$clog2(SUMW+1)-1:0] dcnt_q;
	logic [5:0]      trial;
	assign trial = {rem_q[4:0], quo_q[SUMW-1]};

	// report flag, classification and result
	logic rep_q;
	logic [1:0] tev_q;
	logic       fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSORS; i++) begin
				sum_q[i] <= '0; wpos_q[i] <= '0; full_q[i] <= 1'b0; ssr_q[i] <= '0;
				erep_q[i] <= 1'b0; zone_q[i] <= '0; lowc_q[i] <= '0;
				inc_q[i] <= '0; highc_q[i] <= '0; led_q[i] <= '0;
			end
			wvalid_q <= '0;
			rep_q    <= 1'b0;
			tev_q    <= llwm_pkg::TEV_NONE;
			fault_q  <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			if (cmd.check) begin
				rep_q   <= 1'b0;
				tev_q   <= llwm_pkg::TEV_NONE;
				fault_q <= !skip_q && !ok_now && !erep_q[s];
				// error entry once per error run
				if (!skip_q && !ok_now && !erep_q[s]) begin
					erep_q[s] <= 1'b1; zone_q[s] <= '0; led_q[s] <= '0;
					lowc_q[s] <= '0; inc_q[s] <= '0; highc_q[s] <= '0;
				end
			end
			if (cmd.update) begin
				sum_q[s]  <= new_sum;
				wpos_q[s] <= pn;
				full_q[s] <= new_full;
				ssr_q[s]  <= rep ? 5'd0 : new_ssr;
				erep_q[s] <= 1'b0;
				wvalid_q[addr] <= 1'b1;
				rep_q <= rep;
			end
			if (cmd.div_start) dcnt_q <= ($clog2(SUMW+1))'(SUMW);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.classify) begin
				if ({{(32-SUMW){1'b0}}, sum_q[s]} <= 32'(low_thr_q) * 32'(size)) begin
					if (lowc_q[s] >= 4'(LOW_DEBOUNCE - 1)) begin
						if (!zone_q[s][0]) begin
							lowc_q[s] <= '0; zone_q[s] <= llwm_pkg::ZONE_LOW;
							led_q[s] <= llwm_pkg::LED_BLUE; tev_q <= llwm_pkg::TEV_LOW;
						end else lowc_q[s] <= 4'(LOW_DEBOUNCE);
					end else lowc_q[s] <= lowc_q[s] + 4'd1;
					inc_q[s] <= '0; highc_q[s] <= '0;
				end else if ({{(32-SUMW){1'b0}}, sum_q[s]}
					< 32'(high_thr_q) * 32'(size)) begin
					if (inc_q[s] >= 4'(LOW_DEBOUNCE - 1)) begin
						if (!zone_q[s][1]) begin
							inc_q[s] <= '0; zone_q[s] <= llwm_pkg::ZONE_IN;
							led_q[s] <= llwm_pkg::LED_GREEN;
						end else inc_q[s] <= 4'(LOW_DEBOUNCE);
					end else inc_q[s] <= inc_q[s] + 4'd1;
					lowc_q[s] <= '0;
				end else begin
					if (highc_q[s] >= 4'(HIGH_DEBOUNCE - 1)) begin
						if (!zone_q[s][2]) begin
							highc_q[s] <= '0; zone_q[s] <= llwm_pkg::ZONE_HIGH;
							led_q[s] <= llwm_pkg::LED_RED; tev_q <= llwm_pkg::TEV_HIGH;
						end else highc_q[s] <= 4'(HIGH_DEBOUNCE);
					end else highc_q[s] <= highc_q[s] + 4'd1;
					inc_q[s] <= '0; lowc_q[s] <= '0;
				end
			end
		end
	end

	// divider data path, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q  <= sum_q[s];
			rem_q  <= '0;
		end else if (cmd.div_step && dcnt_q != '0) begin
			if (trial >= {1'b0, size}) begin
				rem_q <= trial - {1'b0, size};
				quo_q <= {quo_q[SUMW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SUMW-2:0], 1'b0};
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sensor_id          <= sidx_q;
			report_valid       <= !skip_q && ok_q && rep_q;
			level_mm           <= (!skip_q && ok_q && rep_q) ?
				((quo_q > SUMW'(15'h7fff)) ? 15'h7fff : quo_q[14:0]) : 15'd0;
			sensor_fault_event <= !skip_q && !ok_q && fault_q;
			threshold_event    <= (!skip_q && ok_q && rep_q) ? tev_q : llwm_pkg::TEV_NONE;
			led_state          <= skip_q ? 3'd0 : led_q[s];
		end
	end

	assign sts.skip     = skip_q;
	assign sts.ok       = ok_now;
	assign sts.report   = rep;
	assign sts.div_done = (dcnt_q == '0);

	// sum never exceeds window capacity
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> {{(32-SUMW){1'b0}}, sum_q[s]} <= 32'(WINDOW_MAX) * 32'h7fff)
		else $error("window sum overflow");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> dcnt_q != '0) else $error("divider not loaded");
	a_no_upd_bad: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> ok_q && !skip_q) else $error("update of invalid sample");

endmodule
